// ----- src/utfd_pkg.sv -----
// Package: decoder state types, lead-byte constants and the font-code map.
`default_nettype none
package utfd_pkg;

	localparam int unsigned AccW = 21;

	// Lead byte thresholds and payload masks
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD2_MIN = 8'hC0;
	localparam logic [7:0] LEAD4_MASK = 8'h07;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;

	// Extra glyphs placed in the C1 hole of the font
	localparam logic [AccW-1:0] CP_ALMOST_EQ = 21'h002248;
	localparam logic [AccW-1:0] CP_BULLET = 21'h002022;
	localparam logic [AccW-1:0] CP_ELLIPSIS = 21'h002026;
	localparam logic [7:0] FC_ALMOST_EQ = 8'h80;
	localparam logic [7:0] FC_BULLET = 8'h81;
	localparam logic [7:0] FC_ELLIPSIS = 8'h82;
	localparam logic [7:0] FC_UNKNOWN = 8'h3F;

	// Control codes that the font has no glyphs for
	localparam logic [AccW-1:0] CP_GAP_LO = 21'h00007F;
	localparam logic [AccW-1:0] CP_GAP_HI = 21'h00009F;
	localparam logic [AccW-1:0] CP_LATIN1_END = 21'h000100;

	typedef struct packed {
		logic [1:0] pending;
		logic [AccW-1:0] acc;
	} dec_state_t;

	typedef struct packed {
		logic emit;
		logic [7:0] code;
		logic last;
	} dec_result_t;

	function automatic logic [7:0] map_code(input logic [AccW-1:0] cp);
		logic [7:0] fc;
		if (cp == CP_ALMOST_EQ) begin
			fc = FC_ALMOST_EQ;
		end else if (cp == CP_BULLET) begin
			fc = FC_BULLET;
		end else if (cp == CP_ELLIPSIS) begin
			fc = FC_ELLIPSIS;
		end else if (cp < CP_LATIN1_END && !(cp >= CP_GAP_LO && cp <= CP_GAP_HI)) begin
			fc = cp[7:0];
		end else begin
			fc = FC_UNKNOWN;
		end
		return fc;
	endfunction

endpackage
`default_nettype wire

// ----- src/utfd_decode.sv -----
// Combinational UTF-8 step: next decoder state and the font code it emits.
`default_nettype none
module utfd_decode
	import utfd_pkg::*;
(
	input  wire logic [7:0] byte_in,
	input  wire logic string_end,
	input  wire dec_state_t state,
	output dec_state_t next_state,
	output dec_result_t result
);

	dec_state_t step;

	// Lead byte classification or continuation shift
	always_comb begin
		step = state;
		if (state.pending == 2'd0) begin
			if (byte_in >= LEAD4_MIN) begin
				step.acc = AccW'(byte_in & LEAD4_MASK);
				step.pending = 2'd3;
			end else if (byte_in >= LEAD3_MIN) begin
				step.acc = AccW'(byte_in & LEAD3_MASK);
				step.pending = 2'd2;
			end else if (byte_in >= LEAD2_MIN) begin
				step.acc = AccW'(byte_in & LEAD2_MASK);
				step.pending = 2'd1;
			end else begin
				step.acc = AccW'(byte_in);
				step.pending = 2'd0;
			end
		end else begin
			step.acc = {state.acc[AccW-7:0], byte_in[5:0]};
			step.pending = state.pending - 2'd1;
		end
	end

	// Emit on a complete sequence or at end of string, then clear
	always_comb begin
		result.emit = (step.pending == 2'd0) || string_end;
		result.code = map_code(step.acc);
		result.last = string_end;
		next_state = result.emit ? '0 : step;
	end

endmodule
`default_nettype wire

// ----- src/utf8_to_font_code_decoder.sv -----
// Top level: UTF-8 byte stream to 8-bit font codes.
// Codes pass the input register, the combinational decode and the result register.
// Throughput: one byte per cycle; the input register advances whenever the single
// result register is empty or being taken this cycle, or its beat emits no code.
// Reset (arst_n low, asynchronous): clears the valid flags and the sequence state.
`default_nettype none
module utf8_to_font_code_decoder
	import utfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [7:0] byte_in,
	input  wire logic string_end,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [7:0] font_code,
	output logic last_code
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic end_s1;
	dec_state_t state_q;
	dec_state_t state_d;
	dec_result_t res;
	logic out_valid_q;
	logic [7:0] code_q;
	logic last_q;
	logic out_free;
	logic advance;

	utfd_decode u_decode (
		.byte_in(byte_s1),
		.string_end(end_s1),
		.state(state_q),
		.next_state(state_d),
		.result(res)
	);

	// Handshake: a beat without a result never waits for the output
	assign out_free = !out_valid_q || !out_stall;
	assign advance = valid_s1 && (!res.emit || out_free);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= byte_in;
			end_s1 <= string_end;
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.emit) begin
			code_q <= res.code;
			last_q <= res.last;
		end
	end

	assign out_valid = out_valid_q;
	assign font_code = code_q;
	assign last_code = last_q;

endmodule
`default_nettype wire

// ----- src/utfd_checker.sv -----
// Port-level checker for the decoder, bound to the top level.
`default_nettype none
module utfd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [7:0] font_code,
	input wire logic last_code
);

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(font_code) && $stable(last_code))
		else $error("result payload changed while stalled");

	// The font has no codes for the C1 range beyond the three extras, nor for DEL
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (font_code < 8'h83 || font_code > 8'h9F) && font_code != 8'h7F)
		else $error("font code outside the glyph set");

	// With the result register empty the input side never stalls
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind utf8_to_font_code_decoder utfd_checker u_utfd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.font_code(font_code),
	.last_code(last_code)
);
`default_nettype wire

// ----- tb/tb_utf8_to_font_code_decoder.sv -----
// Testbench for the UTF-8 to font-code decoder: directed table, random strings, predictor check.
`default_nettype none
module tb_utf8_to_font_code_decoder
	import utfd_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ByteCount = 600;
	localparam int HoldCycles = 48;
	localparam int IdleLimit = 600;

	typedef struct packed {
		logic [7:0] code;
		logic last;
	} glyph_exp_t;

	typedef struct packed {
		logic [7:0] b;
		logic fin;
		logic fixed;
		logic [7:0] code;
		logic last;
	} byte_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] byte_in;
	logic string_end;
	logic out_valid;
	logic out_stall;
	logic [7:0] font_code;
	logic last_code;

	// typed expectation travels with the beat it belongs to
	logic row_fixed;
	logic [7:0] row_code;
	logic row_last;

	glyph_exp_t glyph_q[$];
	logic [1:0] seq_left;
	logic [AccW-1:0] cp_acc;
	int err_cnt = 0;
	int bytes_sent = 0;
	int burst_left = 0;
	int idle_cnt = 0;
	bit hold_req = 1'b0;

	// directed beats; typed results only where obvious
	byte_row_t dir_rows [0:25] = '{
		'{8'h41, 1'b0, 1'b1, 8'h41, 1'b0},
		'{8'h01, 1'b0, 1'b1, 8'h01, 1'b0},
		'{8'h7F, 1'b0, 1'b1, FC_UNKNOWN, 1'b0},
		'{8'hBF, 1'b0, 1'b1, 8'hBF, 1'b0},
		'{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
		'{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hA9, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hE2, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h89, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h88, 1'b0, 1'b1, FC_ALMOST_EQ, 1'b0},
		'{8'hE2, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hA2, 1'b0, 1'b1, FC_BULLET, 1'b0},
		'{8'hE2, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hA6, 1'b0, 1'b1, FC_ELLIPSIS, 1'b0},
		// lead-looking byte taken as continuation
		'{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},
		// zero continuation
		'{8'hC0, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
		// string ends mid-sequence
		'{8'hE2, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h82, 1'b1, 1'b0, 8'h00, 1'b0},
		// largest code point the accumulator holds
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b1, 1'b1, FC_UNKNOWN, 1'b1}
	};

	utf8_to_font_code_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.string_end(string_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.font_code(font_code),
		.last_code(last_code)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// code point to font glyph
	function automatic logic [7:0] glyph_for(input logic [AccW-1:0] cp);
		case (cp)
			CP_ALMOST_EQ: return FC_ALMOST_EQ;
			CP_BULLET: return FC_BULLET;
			CP_ELLIPSIS: return FC_ELLIPSIS;
			default: begin
				if (cp[AccW-1:8] == '0 && (cp < CP_GAP_LO || cp > CP_GAP_HI))
					return cp[7:0];
				return FC_UNKNOWN;
			end
		endcase
	endfunction

	// advance the sequence state by one byte; emit set when a glyph comes out
	function automatic void decode_byte(input logic [7:0] b, input logic fin,
			output logic emit, output logic [7:0] code);
		if (seq_left == 2'd0) begin
			if (b >= LEAD4_MIN) begin
				cp_acc = AccW'(b & LEAD4_MASK);
				seq_left = 2'd3;
			end else if (b >= LEAD3_MIN) begin
				cp_acc = AccW'(b & LEAD3_MASK);
				seq_left = 2'd2;
			end else if (b >= LEAD2_MIN) begin
				cp_acc = AccW'(b & LEAD2_MASK);
				seq_left = 2'd1;
			end else begin
				cp_acc = AccW'(b);
			end
		end else begin
			cp_acc = {cp_acc[AccW-7:0], b[5:0]};
			seq_left = seq_left - 2'd1;
		end
		emit = (seq_left == 2'd0) || fin;
		code = 8'h00;
		if (emit) begin
			code = glyph_for(cp_acc);
			seq_left = 2'd0;
			cp_acc = '0;
		end
	endfunction

	task automatic report_mismatch(input string what);
		err_cnt++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// result check, then prediction for the beat taken at this edge
	always @(posedge clk) begin
		glyph_exp_t want;
		logic emit;
		logic [7:0] code;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (glyph_q.size() == 0) begin
					report_mismatch($sformatf("unexpected glyph %02h last %0b",
						font_code, last_code));
				end else begin
					want = glyph_q.pop_front();
					if (font_code !== want.code)
						report_mismatch($sformatf("font_code %02h, want %02h",
							font_code, want.code));
					if (last_code !== want.last)
						report_mismatch($sformatf("last_code %0b, want %0b",
							last_code, want.last));
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(byte_in, string_end, emit, code);
				if (emit) begin
					if (row_fixed)
						glyph_q.push_back(glyph_exp_t'{row_code, row_last});
					else
						glyph_q.push_back(glyph_exp_t'{code, string_end});
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cnt <= 0;
		end else if (idle_cnt >= IdleLimit) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	// receiver: long hold on request, otherwise a rotating stall pattern
	initial begin
		int ph;
		ph = 0;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				ph++;
				case ((ph / 64) % 4)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= (ph % 3 == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(negedge clk);
			end
		end
	end

	// send one beat in bursts; entered and left at a falling edge
	task automatic drive_byte(input logic [7:0] b, input logic fin, input logic fx,
			input logic [7:0] fc, input logic fl);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		string_end <= fin;
		row_fixed <= fx;
		row_code <= fc;
		row_last <= fl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// sender waits until every glyph has come out
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (glyph_q.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(1, 255));
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	// one random sequence, mostly well formed
	task automatic send_sequence();
		logic [7:0] seq [0:3];
		int n;
		int kind;
		logic fin;
		kind = $urandom_range(0, 99);
		fin = ($urandom_range(0, 7) == 0);
		n = 1;
		if (kind < 30) begin
			seq[0] = 8'($urandom_range(1, 127));
		end else if (kind < 50) begin
			seq[0] = ($urandom_range(0, 2) == 0) ? (8'hC0 | 8'($urandom_range(0, 31)))
				: (8'hC2 + 8'($urandom_range(0, 1)));
			seq[1] = cont_byte();
			n = 2;
		end else if (kind < 58) begin
			seq[0] = 8'hE2;
			case ($urandom_range(0, 2))
				0: begin seq[1] = 8'h89; seq[2] = 8'h88; end
				1: begin seq[1] = 8'h80; seq[2] = 8'hA2; end
				default: begin seq[1] = 8'h80; seq[2] = 8'hA6; end
			endcase
			n = 3;
		end else if (kind < 70) begin
			seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
			seq[1] = cont_byte();
			seq[2] = cont_byte();
			n = 3;
		end else if (kind < 78) begin
			seq[0] = 8'hF0 | 8'($urandom_range(0, 15));
			for (int i = 1; i < 4; i++) seq[i] = cont_byte();
			n = 4;
		end else if (kind < 86) begin
			// truncated: string ends before the sequence completes
			n = $urandom_range(1, 3);
			seq[0] = 8'hF0 | 8'($urandom_range(0, 15));
			if (n < 3 && $urandom_range(0, 1) == 1)
				seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
			if (n < 2 && $urandom_range(0, 1) == 1)
				seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
			for (int i = 1; i < n; i++) seq[i] = cont_byte();
			fin = 1'b1;
		end else begin
			seq[0] = 8'($urandom_range(1, 255));
			fin = 1'($urandom_range(0, 1));
		end
		for (int i = 0; i < n; i++)
			drive_byte(seq[i], fin && (i == n - 1), 1'b0, 8'h00, 1'b0);
	endtask

	// main stimulus
	initial begin
		bit held_a;
		bit held_b;
		bit drained;
		held_a = 1'b0;
		held_b = 1'b0;
		drained = 1'b0;
		seq_left = 2'd0;
		cp_acc = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = 8'h00;
		string_end = 1'b0;
		row_fixed = 1'b0;
		row_code = 8'h00;
		row_last = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			drive_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].fixed,
				dir_rows[i].code, dir_rows[i].last);

		while (bytes_sent < ByteCount) begin
			if (!held_a && bytes_sent >= 150) begin
				held_a = 1'b1;
				hold_req = 1'b1;
			end
			if (!drained && bytes_sent >= 300) begin
				drained = 1'b1;
				pause_until_drained();
			end
			if (!held_b && bytes_sent >= 450) begin
				held_b = 1'b1;
				hold_req = 1'b1;
			end
			send_sequence();
		end

		in_valid <= 1'b0;
		while (glyph_q.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
